>>> hdl/dfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the dimmer fade ramp.
package dfr_pkg;

    localparam logic [1:0] CMD_SET_LEVEL = 2'd0;
    localparam logic [1:0] CMD_TICK      = 2'd1;
    localparam logic [1:0] CMD_STOP      = 2'd2;

    localparam logic [1:0] REG_FADE_ENABLE  = 2'd0;
    localparam logic [1:0] REG_DEFAULT_RATE = 2'd1;
    localparam logic [1:0] REG_LOWEST_DELAY = 2'd2;

    localparam logic [6:0]  LEVEL_FULL       = 7'd100;
    localparam logic [6:0]  LEVEL_HALF       = 7'd50;
    localparam logic [7:0]  RATE_MAX         = 8'd15;
    localparam logic [3:0]  RATE_RESET       = 4'd1;
    localparam logic [15:0] LOWEST_DELAY_RST = 16'd11998;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] level;
        logic [7:0] fade_rate;
    } item_t;

    typedef struct packed {
        logic        applied;
        logic        compare_enable;
        logic [15:0] compare_value;
        logic [6:0]  current_level;
        logic [6:0]  target_level;
    } result_t;

    typedef struct packed {
        logic        fade_enable;
        logic [3:0]  default_fade_rate;
        logic [15:0] lowest_level_delay;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  level_now;
        logic [6:0]  level_goal;
        logic [3:0]  rate_held;
        logic [11:0] tick_countdown;
        logic        compare_on;
        logic [15:0] compare_word;
    } state_t;

    // Ticks to wait between level steps for fade rates 1 to 15
    function automatic logic [11:0] divider_for_rate(logic [3:0] rate);
        logic [11:0] div;
        case (rate)
            4'd1:    div = 12'd0;
            4'd2:    div = 12'd1;
            4'd3:    div = 12'd2;
            4'd4:    div = 12'd4;
            4'd5:    div = 12'd6;
            4'd6:    div = 12'd9;
            4'd7:    div = 12'd19;
            4'd8:    div = 12'd29;
            4'd9:    div = 12'd59;
            4'd10:   div = 12'd119;
            4'd11:   div = 12'd299;
            4'd12:   div = 12'd599;
            4'd13:   div = 12'd899;
            4'd14:   div = 12'd1799;
            4'd15:   div = 12'd3599;
            default: div = 12'd0;
        endcase
        return div;
    endfunction

    // Triac firing delay for levels 2 to 100 percent
    function automatic logic [15:0] delay_for_level(logic [6:0] lvl);
        logic [15:0] d;
        case (lvl)
            7'd2:  d = 16'd11993;  7'd3:  d = 16'd11982;  7'd4:  d = 16'd11967;
            7'd5:  d = 16'd11948;  7'd6:  d = 16'd11924;  7'd7:  d = 16'd11896;
            7'd8:  d = 16'd11864;  7'd9:  d = 16'd11827;  7'd10: d = 16'd11787;
            7'd11: d = 16'd11742;  7'd12: d = 16'd11692;  7'd13: d = 16'd11640;
            7'd14: d = 16'd11583;  7'd15: d = 16'd11522;  7'd16: d = 16'd11457;
            7'd17: d = 16'd11389;  7'd18: d = 16'd11317;  7'd19: d = 16'd11241;
            7'd20: d = 16'd11161;  7'd21: d = 16'd11079;  7'd22: d = 16'd10992;
            7'd23: d = 16'd10902;  7'd24: d = 16'd10809;  7'd25: d = 16'd10713;
            7'd26: d = 16'd10614;  7'd27: d = 16'd10512;  7'd28: d = 16'd10407;
            7'd29: d = 16'd10299;  7'd30: d = 16'd10188;  7'd31: d = 16'd10075;
            7'd32: d = 16'd9960;   7'd33: d = 16'd9841;   7'd34: d = 16'd9721;
            7'd35: d = 16'd9600;   7'd36: d = 16'd9476;   7'd37: d = 16'd9349;
            7'd38: d = 16'd9221;   7'd39: d = 16'd9092;   7'd40: d = 16'd8961;
            7'd41: d = 16'd8829;   7'd42: d = 16'd8696;   7'd43: d = 16'd8562;
            7'd44: d = 16'd8426;   7'd45: d = 16'd8290;   7'd46: d = 16'd8153;
            7'd47: d = 16'd8016;   7'd48: d = 16'd7878;   7'd49: d = 16'd7740;
            7'd50: d = 16'd7602;   7'd51: d = 16'd7464;   7'd52: d = 16'd7325;
            7'd53: d = 16'd7188;   7'd54: d = 16'd7050;   7'd55: d = 16'd6913;
            7'd56: d = 16'd6777;   7'd57: d = 16'd6642;   7'd58: d = 16'd6508;
            7'd59: d = 16'd6374;   7'd60: d = 16'd6242;   7'd61: d = 16'd6112;
            7'd62: d = 16'd5982;   7'd63: d = 16'd5854;   7'd64: d = 16'd5728;
            7'd65: d = 16'd5604;   7'd66: d = 16'd5482;   7'd67: d = 16'd5362;
            7'd68: d = 16'd5244;   7'd69: d = 16'd5128;   7'd70: d = 16'd5016;
            7'd71: d = 16'd4905;   7'd72: d = 16'd4797;   7'd73: d = 16'd4692;
            7'd74: d = 16'd4590;   7'd75: d = 16'd4491;   7'd76: d = 16'd4394;
            7'd77: d = 16'd4301;   7'd78: d = 16'd4212;   7'd79: d = 16'd4125;
            7'd80: d = 16'd4042;   7'd81: d = 16'd3963;   7'd82: d = 16'd3887;
            7'd83: d = 16'd3815;   7'd84: d = 16'd3746;   7'd85: d = 16'd3681;
            7'd86: d = 16'd3620;   7'd87: d = 16'd3564;   7'd88: d = 16'd3511;
            7'd89: d = 16'd3462;   7'd90: d = 16'd3417;   7'd91: d = 16'd3376;
            7'd92: d = 16'd3340;   7'd93: d = 16'd3308;   7'd94: d = 16'd3280;
            7'd95: d = 16'd3256;   7'd96: d = 16'd3236;   7'd97: d = 16'd3221;
            7'd98: d = 16'd3211;   7'd99: d = 16'd3204;   7'd100: d = 16'd3202;
            default: d = 16'd0;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/dfr_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one command of the dimmer fade ramp.
module dfr_step
    import dfr_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  state,
    input  item_t   item,
    output state_t  state_next,
    output result_t result
);

    logic [6:0] lvl_clamp;
    logic       same_set;
    logic [3:0] rate_sel;
    logic [6:0] goal_sel;
    logic [6:0] new_level;
    logic       load_cmp;
    logic       applied;

    assign lvl_clamp = (item.level > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : item.level[6:0];
    assign same_set  = (state.level_goal == lvl_clamp) &&
                       ({4'd0, state.rate_held} == item.fade_rate);

    always_comb
    begin
        rate_sel = (item.fade_rate > RATE_MAX) ? cfg.default_fade_rate : item.fade_rate[3:0];
        goal_sel = lvl_clamp;
        if (!cfg.fade_enable)
        begin
            // on/off only: round at half and snap
            rate_sel = 4'd0;
            goal_sel = (lvl_clamp > LEVEL_HALF) ? LEVEL_FULL : 7'd0;
        end
    end

    always_comb
    begin
        state_next = state;
        new_level  = state.level_now;
        load_cmp   = 1'b0;
        applied    = 1'b0;
        case (item.cmd)
            CMD_SET_LEVEL:
            begin
                if (!same_set)
                begin
                    state_next.level_goal = goal_sel;
                    state_next.rate_held  = rate_sel;
                    if (rate_sel == 4'd0)
                    begin
                        new_level = goal_sel;
                        load_cmp  = 1'b1;
                    end
                    else
                    begin
                        state_next.tick_countdown = divider_for_rate(rate_sel);
                    end
                end
            end
            CMD_TICK:
            begin
                if (state.level_now != state.level_goal)
                begin
                    if (state.tick_countdown != 12'd0)
                    begin
                        state_next.tick_countdown = state.tick_countdown - 12'd1;
                    end
                    else
                    begin
                        new_level = (state.level_goal > state.level_now) ?
                                    state.level_now + 7'd1 : state.level_now - 7'd1;
                        load_cmp  = 1'b1;
                        state_next.tick_countdown = (state.rate_held == 4'd0) ?
                                    12'd0 : divider_for_rate(state.rate_held);
                    end
                end
            end
            CMD_STOP:
            begin
                state_next.level_goal = state.level_now;
            end
            default:
            begin
                state_next = state;
            end
        endcase

        if (load_cmp)
        begin
            applied              = 1'b1;
            state_next.level_now = new_level;
            if (new_level == 7'd0)
            begin
                state_next.compare_on = 1'b0;
            end
            else if (new_level == 7'd1)
            begin
                state_next.compare_on   = 1'b1;
                state_next.compare_word = cfg.lowest_level_delay;
            end
            else
            begin
                state_next.compare_on   = 1'b1;
                state_next.compare_word = delay_for_level(new_level);
            end
        end
    end

    assign result.applied        = applied;
    assign result.compare_enable = state_next.compare_on;
    assign result.compare_value  = state_next.compare_word;
    assign result.current_level  = state_next.level_now;
    assign result.target_level   = state_next.level_goal;

endmodule

>>> hdl/dimmer_fade_ramp.sv
`timescale 1ns / 1ps
// Top level of the dimmer fade ramp: command register, state and result register.
// Path: the transfer edge loads the command register; the result register then loads
//   from the step logic when it is free, and a result stall holds the command there.
// Throughput: one command per cycle through the single step logic, if not stalled.
// Reset: fade state, compare and both stages clear; registers return to fades enabled,
//   default rate 1 and a lowest-level delay of 11998.
module dimmer_fade_ramp
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  item_t       cmd_data,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output result_t     res_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    hold_valid_reg;
    item_t   hold_data_reg;
    logic    res_valid_reg;
    result_t res_data_reg;
    result_t step_result;
    logic    res_free;
    logic    advance;
    logic    cfg_write;

    // ------------------------------------------------------------------
    // Register port: always ready, write in the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_enable        <= 1'b1;
            cfg_reg.default_fade_rate  <= RATE_RESET;
            cfg_reg.lowest_level_delay <= LOWEST_DELAY_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FADE_ENABLE:  cfg_reg.fade_enable <= pwdata[0];
                // a default rate of zero would leave fades stuck: store 1 instead
                REG_DEFAULT_RATE: cfg_reg.default_fade_rate <=
                                  (pwdata[3:0] == 4'd0) ? RATE_RESET : pwdata[3:0];
                REG_LOWEST_DELAY: cfg_reg.lowest_level_delay <= pwdata[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FADE_ENABLE:  prdata = {31'd0, cfg_reg.fade_enable};
            REG_DEFAULT_RATE: prdata = {28'd0, cfg_reg.default_fade_rate};
            REG_LOWEST_DELAY: prdata = {16'd0, cfg_reg.lowest_level_delay};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the result register takes a new result when empty or
    // when its current one is leaving; the command register advances then.
    // ------------------------------------------------------------------
    assign res_free  = !res_valid_reg || !res_stall;
    assign advance   = hold_valid_reg && res_free;
    assign cmd_stall = hold_valid_reg && !res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            hold_valid_reg <= cmd_valid;
        end
    end

    // payload needs no reset; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            hold_data_reg <= cmd_data;
        end
    end

    // ------------------------------------------------------------------
    // Step logic: state advances only as a command moves to the result
    // ------------------------------------------------------------------
    dfr_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (hold_data_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (res_free)
            begin
                res_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg <= step_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.level_now <= LEVEL_FULL && state_reg.level_goal <= LEVEL_FULL)
        else $error("fade level left the 0 to 100 range");

    a_default_rate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.default_fade_rate != 4'd0)
        else $error("default fade rate holds zero");

    a_applied_enable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.applied |->
            res_data.compare_enable == (res_data.current_level != 7'd0))
        else $error("compare enable disagrees with the level just applied");

    a_stop_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && hold_data_reg.cmd == CMD_STOP |=>
            res_data.target_level == res_data.current_level && !res_data.applied)
        else $error("stop did not freeze the target at the current level");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> hold_valid_reg && res_valid_reg && res_stall)
        else $error("command stalled with room downstream");

endmodule

>>> bench/dimmer_fade_ramp_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the dimmer fade ramp: directed table, then random fades under stalls.
module dimmer_fade_ramp_test;
    import dfr_pkg::*;

    // The command field is two bits wide, so code 3 can arrive and must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Random transfers per register setting, cycles to settle after the last result,
    // and a cap on printed mismatches so a broken build cannot flood the log
    localparam int SEG_ITEMS     = 270;
    localparam int SEG_COUNT     = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 200;

    // Zero-cross ticks to wait between level steps, indexed by fade rate minus one
    localparam logic [11:0] DIVIDER_TAB [0:14] = '{
        12'd0, 12'd1, 12'd2, 12'd4, 12'd6, 12'd9, 12'd19, 12'd29,
        12'd59, 12'd119, 12'd299, 12'd599, 12'd899, 12'd1799, 12'd3599
    };

    // Triac firing delay for 2..100 percent; 1 percent comes from a register
    localparam logic [15:0] DELAY_TAB [0:98] = '{
        16'd11993, 16'd11982, 16'd11967, 16'd11948, 16'd11924,
        16'd11896, 16'd11864, 16'd11827, 16'd11787, 16'd11742,
        16'd11692, 16'd11640, 16'd11583, 16'd11522, 16'd11457,
        16'd11389, 16'd11317, 16'd11241, 16'd11161, 16'd11079,
        16'd10992, 16'd10902, 16'd10809, 16'd10713, 16'd10614,
        16'd10512, 16'd10407, 16'd10299, 16'd10188, 16'd10075,
        16'd9960,  16'd9841,  16'd9721,  16'd9600,  16'd9476,
        16'd9349,  16'd9221,  16'd9092,  16'd8961,  16'd8829,
        16'd8696,  16'd8562,  16'd8426,  16'd8290,  16'd8153,
        16'd8016,  16'd7878,  16'd7740,  16'd7602,  16'd7464,
        16'd7325,  16'd7188,  16'd7050,  16'd6913,  16'd6777,
        16'd6642,  16'd6508,  16'd6374,  16'd6242,  16'd6112,
        16'd5982,  16'd5854,  16'd5728,  16'd5604,  16'd5482,
        16'd5362,  16'd5244,  16'd5128,  16'd5016,  16'd4905,
        16'd4797,  16'd4692,  16'd4590,  16'd4491,  16'd4394,
        16'd4301,  16'd4212,  16'd4125,  16'd4042,  16'd3963,
        16'd3887,  16'd3815,  16'd3746,  16'd3681,  16'd3620,
        16'd3564,  16'd3511,  16'd3462,  16'd3417,  16'd3376,
        16'd3340,  16'd3308,  16'd3280,  16'd3256,  16'd3236,
        16'd3221,  16'd3211,  16'd3204,  16'd3202
    };

    // One row of the directed table: the command, and a hand-typed result where it is obvious
    typedef struct packed {
        item_t   stim;
        logic    fixed;
        result_t want;
    } dir_row_t;

    // Clock, reset and every block input start at known values
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    item_t       cmd_data  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    result_t     res_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies held by the predictor
    logic        cfg_mode         = 1'b1;
    logic [3:0]  cfg_default_rate = RATE_RESET;
    logic [15:0] cfg_lowest_delay = LOWEST_DELAY_RST;

    // Fade state held by the predictor, all clear after reset
    logic [6:0]  lvl_now   = '0;
    logic [6:0]  lvl_goal  = '0;
    logic [3:0]  rate_kept = '0;
    logic [11:0] tick_left = '0;
    logic        cmp_on    = 1'b0;
    logic [15:0] cmp_word  = '0;

    result_t  pending_results [$];
    dir_row_t dir_rows [$];

    int send_idle_pct   = 37;
    int stall_pct       = 58;
    int items_sent      = 0;
    int results_checked = 0;
    int steps_seen      = 0;
    int fail_count      = 0;

    dimmer_fade_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // Give up after a fixed time far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Load the compare from the current level: off at 0 percent, keeping the last word
    function automatic void load_compare_word();
        if (lvl_now == 7'd0)
            cmp_on = 1'b0;
        else if (lvl_now == 7'd1)
        begin
            cmp_word = cfg_lowest_delay;
            cmp_on   = 1'b1;
        end
        else
        begin
            cmp_word = DELAY_TAB[lvl_now - 7'd2];
            cmp_on   = 1'b1;
        end
    endfunction

    // Restart the tick divider for the held rate
    function automatic void reload_tick_divider();
        if (rate_kept == 4'd0)
            tick_left = '0;
        else
            tick_left = DIVIDER_TAB[rate_kept - 4'd1];
    endfunction

    // Advance the predicted fade state by one command and return the result it gives
    function automatic result_t fade_step(input item_t it);
        logic [7:0] asked;
        logic       moved;
        moved = 1'b0;
        case (it.cmd)
            CMD_SET_LEVEL:
            begin
                asked = (it.level > {1'b0, LEVEL_FULL}) ? {1'b0, LEVEL_FULL} : it.level;
                // A set that repeats the held goal and rate changes nothing
                if (!(asked == {1'b0, lvl_goal} && it.fade_rate == {4'b0, rate_kept}))
                begin
                    lvl_goal  = asked[6:0];
                    rate_kept = (it.fade_rate > RATE_MAX) ? cfg_default_rate
                                                          : it.fade_rate[3:0];
                    // On/off mode: no fades, and the goal rounds to off or full
                    if (cfg_mode != 1'b1)
                    begin
                        rate_kept = '0;
                        lvl_goal  = (lvl_goal > LEVEL_HALF) ? LEVEL_FULL : 7'd0;
                    end
                    if (rate_kept == 4'd0)
                    begin
                        lvl_now = lvl_goal;
                        load_compare_word();
                        moved = 1'b1;
                    end
                    else
                        reload_tick_divider();
                end
            end
            CMD_TICK:
            begin
                if (lvl_now != lvl_goal)
                begin
                    if (tick_left != '0)
                        tick_left = tick_left - 12'd1;
                    else
                    begin
                        lvl_now = (lvl_goal > lvl_now) ? lvl_now + 7'd1 : lvl_now - 7'd1;
                        load_compare_word();
                        moved = 1'b1;
                        reload_tick_divider();
                    end
                end
            end
            CMD_STOP:
                lvl_goal = lvl_now;
            default:
                ;
        endcase
        return {moved, cmp_on, cmp_word, lvl_now, lvl_goal};
    endfunction

    // Level choice for set commands, leaning on the rounding point and the range ends
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'(50 + $urandom_range(0, 1));
            1:       return 8'($urandom_range(101, 255));
            2:       return 8'($urandom_range(0, 1) * 99 + $urandom_range(0, 1));
            default: return 8'($urandom_range(0, 100));
        endcase
    endfunction

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("t=%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic add_row(input logic [1:0] c, input logic [7:0] lvl, input logic [7:0] rate,
                           input logic fixed, input result_t want);
        dir_rows.push_back({c, lvl, rate, fixed, want});
    endtask

    // Present one command, hold it until the transfer, then log its expected result
    task automatic send_item(input item_t it, input logic fixed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= it;
        do @(posedge clk); while (cmd_stall);
        predicted = fade_step(it);
        pending_results.push_back(fixed ? want : predicted);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_plain(input logic [1:0] c, input logic [7:0] lvl,
                              input logic [7:0] rate);
        send_item({c, lvl, rate}, 1'b0, '0);
    endtask

    // Drop valid and hold off until every result is back and the pipeline is quiet
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the write on the ready edge
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] mask,
                                  input logic [31:0] want, input string what);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        report_field(what, want, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write all three registers with junk above each field, mirror them, then read them back
    task automatic set_registers(input logic mode, input logic [3:0] rate,
                                 input logic [15:0] delay);
        apb_write(REG_FADE_ENABLE,  {31'($urandom), mode});
        apb_write(REG_DEFAULT_RATE, {28'($urandom), rate});
        apb_write(REG_LOWEST_DELAY, {16'($urandom), delay});
        cfg_mode         = mode;
        // A zero default rate is stored as 1
        cfg_default_rate = (rate == 4'd0) ? 4'd1 : rate;
        cfg_lowest_delay = delay;
        apb_read_check(REG_FADE_ENABLE,  32'h1,    {31'b0, cfg_mode},         "fade_enable");
        apb_read_check(REG_DEFAULT_RATE, 32'hF,    {28'b0, cfg_default_rate}, "default_fade_rate");
        apb_read_check(REG_LOWEST_DELAY, 32'hFFFF, {16'b0, cfg_lowest_delay}, "lowest_level_delay");
    endtask

    // Result side: stall at random and compare every transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        res_stall <= ($urandom_range(0, 99) < stall_pct);
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("t=%0t: result with nothing expected, expected none, got %h",
                             $time, res_data);
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("applied",        want.applied,        res_data.applied);
                report_field("compare_enable", want.compare_enable, res_data.compare_enable);
                report_field("compare_value",  want.compare_value,  res_data.compare_value);
                report_field("current_level",  want.current_level,  res_data.current_level);
                report_field("target_level",   want.target_level,   res_data.target_level);
                results_checked++;
                if (res_data.applied)
                    steps_seen++;
            end
        end
    end

    initial
    begin
        int     seg;
        int     seg_start;
        int     n;
        int     k;
        int     pick;
        logic [7:0] rate;

        // Directed table: reset state, unknown command, range ends, snaps, fades and stops
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b1, {1'b0, 1'b0, 16'd0,     7'd0,   7'd0});
        add_row(CMD_STOP,       8'd0,   8'd0,   1'b1, {1'b0, 1'b0, 16'd0,     7'd0,   7'd0});
        add_row(CMD_UNUSED,     8'd255, 8'd255, 1'b1, {1'b0, 1'b0, 16'd0,     7'd0,   7'd0});
        add_row(CMD_SET_LEVEL,  8'd1,   8'd0,   1'b1, {1'b1, 1'b1, 16'd11998, 7'd1,   7'd1});
        add_row(CMD_SET_LEVEL,  8'd255, 8'd0,   1'b1, {1'b1, 1'b1, 16'd3202,  7'd100, 7'd100});
        // Same goal and rate again: nothing moves
        add_row(CMD_SET_LEVEL,  8'd100, 8'd0,   1'b1, {1'b0, 1'b1, 16'd3202,  7'd100, 7'd100});
        // Snap to off: compare drops but keeps its last word
        add_row(CMD_SET_LEVEL,  8'd0,   8'd0,   1'b1, {1'b1, 1'b0, 16'd3202,  7'd0,   7'd0});
        add_row(CMD_SET_LEVEL,  8'd2,   8'd0,   1'b1, {1'b1, 1'b1, 16'd11993, 7'd2,   7'd2});
        // Start a fade: only the divider loads, the first step waits for a tick
        add_row(CMD_SET_LEVEL,  8'd5,   8'd1,   1'b1, {1'b0, 1'b1, 16'd11993, 7'd2,   7'd5});
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_TICK,       8'd255, 8'd255, 1'b0, '0);
        add_row(CMD_STOP,       8'd0,   8'd0,   1'b1, {1'b0, 1'b1, 16'd11967, 7'd4,   7'd4});
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_SET_LEVEL,  8'd0,   8'd2,   1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        // Rate above 15 falls back to the default rate
        add_row(CMD_SET_LEVEL,  8'd0,   8'd200, 1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b1, {1'b1, 1'b0, 16'd11998, 7'd0,   7'd0});
        add_row(CMD_SET_LEVEL,  8'd101, 8'd16,  1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        // Slowest rate: the divider starts at its top value
        add_row(CMD_SET_LEVEL,  8'd100, 8'd15,  1'b0, '0);
        add_row(CMD_TICK,       8'd0,   8'd0,   1'b0, '0);
        add_row(CMD_STOP,       8'd77,  8'd3,   1'b0, '0);

        // Hold reset, then release it on a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_registers(1'b1, RATE_RESET, LOWEST_DELAY_RST);
        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

        for (seg = 0; seg < SEG_COUNT; seg++)
        begin
            drain_results();
            // Receiver stalls more, then sender idles more, then neither holds back
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 37;
                    stall_pct     = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    stall_pct     = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            case (seg)
                0:       set_registers(1'b1, 4'd3,  LOWEST_DELAY_RST);
                1:       set_registers(1'b0, 4'd0,  16'd0);
                2:       set_registers(1'b1, 4'd15, 16'hFFFF);
                3:       set_registers(1'b1, 4'd7,  16'($urandom));
                4:       set_registers(1'b0, 4'd9,  16'hFFFF);
                default: set_registers(1'b1, 4'($urandom_range(1, 15)), 16'($urandom));
            endcase

            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // Well-formed fade: a set, then a run of ticks with the odd stop
                    case ($urandom_range(0, 9))
                        0:       rate = 8'd0;
                        1:       rate = 8'($urandom_range(16, 255));
                        2:       rate = 8'($urandom_range(5, 9));
                        default: rate = 8'($urandom_range(1, 4));
                    endcase
                    send_plain(CMD_SET_LEVEL, pick_level(), rate);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                    : $urandom_range(1, 30);
                    for (k = 0; k < n && items_sent - seg_start < SEG_ITEMS; k++)
                    begin
                        if ($urandom_range(0, 49) == 0)
                            send_plain(CMD_STOP, 8'($urandom), 8'($urandom));
                        else
                            send_plain(CMD_TICK, 8'($urandom), 8'($urandom));
                    end
                end
                else if (pick < 65)
                    // Repeat the held goal and rate
                    send_plain(CMD_SET_LEVEL, {1'b0, lvl_goal}, {4'b0, rate_kept});
                else if (pick < 67)
                begin
                    // Slow fade, long enough for the mid-range dividers to run out
                    send_plain(CMD_SET_LEVEL, pick_level(), 8'($urandom_range(10, 15)));
                    n = $urandom_range(1, 320);
                    for (k = 0; k < n && items_sent - seg_start < SEG_ITEMS; k++)
                        send_plain(CMD_TICK, 8'($urandom), 8'($urandom));
                end
                else
                    // Noise: any command code with any field content
                    send_plain(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
        end

        drain_results();

        $display("Run covered %0d commands across 7 register settings; %0d results compared.",
                 items_sent, results_checked);
        $display("%0d of those results moved the compare (snaps and fade steps).", steps_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/dfr_pkg.sv
hdl/dfr_step.sv
hdl/dimmer_fade_ramp.sv
bench/dimmer_fade_ramp_test.sv
